/* sv/sdf_pkg.sv */
// ----------------------------------------------------------------------------
// sdf_pkg
// shared widths, state encoding and hash helper for the duplicate filter
// ----------------------------------------------------------------------------
`default_nettype none

package sdf_pkg;

   // payload widths
   localparam int VALUE_W = 32;
   localparam int HASH_W  = 16;

   // generation tag kept next to each stored value, zero marks a cleared slot
   localparam int EPOCH_W = 8;
   localparam logic [EPOCH_W-1:0] EPOCH_NONE  = '0;
   localparam logic [EPOCH_W-1:0] EPOCH_FIRST = EPOCH_W'(1);
   localparam logic [EPOCH_W-1:0] EPOCH_LAST  = '1;

   localparam int ENTRY_W = EPOCH_W + VALUE_W;

   // controller states, one-hot
   typedef enum logic [4:0] {
      ST_SWEEP = 5'b00001,
      ST_IDLE  = 5'b00010,
      ST_HASH  = 5'b00100,
      ST_LOOK  = 5'b01000,
      ST_EMIT  = 5'b10000
   } state_type;

   // fold a value down to a 16 bit key for the table index
   function automatic logic [HASH_W-1:0] fold_value(input logic [VALUE_W-1:0] v);
      logic [HASH_W-1:0] f;
      f = v[31:16] ^ v[15:0];
      return f ^ (f >> 7);
   endfunction

endpackage

`default_nettype wire

/* sv/sdf_req_if.sv */
// ----------------------------------------------------------------------------
// sdf_req_if
// request channel: one value plus the new-list flag, valid/ready handshake
// ----------------------------------------------------------------------------
`default_nettype none

interface sdf_req_if;
   logic        valid;
   logic        ready;
   logic [31:0] item_value;
   logic        starts_new_list;

   modport source (output valid, output item_value, output starts_new_list, input ready);
   modport sink   (input valid, input item_value, input starts_new_list, output ready);
endinterface

`default_nettype wire

/* sv/sdf_rsp_if.sv */
// ----------------------------------------------------------------------------
// sdf_rsp_if
// result channel: a kept value and its overflow flag, valid/ready handshake
// ----------------------------------------------------------------------------
`default_nettype none

interface sdf_rsp_if;
   logic        valid;
   logic        ready;
   logic [31:0] kept_value;
   logic        set_overflow;

   modport source (output valid, output kept_value, output set_overflow, input ready);
   modport sink   (input valid, input kept_value, input set_overflow, output ready);
endinterface

`default_nettype wire

/* sv/sdf_ram.sv */
// ----------------------------------------------------------------------------
// sdf_ram
// generic single write port, single read port ram with registered read data
// ----------------------------------------------------------------------------
`default_nettype none

module sdf_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // registered read port
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule

`default_nettype wire

/* sv/stream_duplicate_filter.sv */
// ----------------------------------------------------------------------------
// stream_duplicate_filter
// passes on the first occurrence of each 32 bit value since the last new-list
// flag; the seen set is an open-addressed hash table in one ram
// ----------------------------------------------------------------------------
// flow: an accepted request has its home slot read, then the table is probed
//   (linear probing, one probe per cycle out of the ram read port) to a match,
//   a free slot, or SEEN_CAPACITY probes on a full table; a drop returns to idle,
//   a kept value waits for the output register, and only then is a new one taken
// reset: seen count cleared, then a clearing pass over every ram slot with req
//   ready low; the same pass runs on every 255th new list
// ----------------------------------------------------------------------------
`default_nettype none

module stream_duplicate_filter
   import sdf_pkg::*;
#(
   parameter int SEEN_CAPACITY = 256
) (
   input  wire logic  clock,
   input  wire logic  reset,
   sdf_req_if.sink    req_chan,
   sdf_rsp_if.source  rsp_chan
);

   localparam int IDX_W = $clog2(SEEN_CAPACITY);
   localparam int CNT_W = $clog2(SEEN_CAPACITY + 1);
   localparam int PROD_W = HASH_W + CNT_W;
   localparam logic [IDX_W-1:0] IDX_LAST   = IDX_W'(SEEN_CAPACITY - 1);
   localparam logic [CNT_W-1:0] PROBE_LAST = CNT_W'(SEEN_CAPACITY - 1);
   localparam logic [CNT_W-1:0] CNT_FULL   = CNT_W'(SEEN_CAPACITY);

   // control state
   state_type          state_ff, state_in;
   logic [EPOCH_W-1:0] epoch_ff, epoch_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic [CNT_W-1:0]   probe_cnt_ff, probe_cnt_in;
   logic [IDX_W-1:0]   sweep_ff, sweep_in;
   logic               item_pend_ff, item_pend_in;
   logic               rsp_valid_ff, rsp_valid_in;

   // payload registers
   logic [VALUE_W-1:0] item_ff, item_in;
   logic [IDX_W-1:0]   addr_ff, addr_in;
   logic               ovf_ff, ovf_in;
   logic [VALUE_W-1:0] rsp_value_ff, rsp_value_in;
   logic               rsp_ovf_ff, rsp_ovf_in;

   // ram ports
   logic               wr_en;
   logic [IDX_W-1:0]   wr_addr;
   logic [ENTRY_W-1:0] wr_data;
   logic               rd_en;
   logic [IDX_W-1:0]   rd_addr;
   logic [ENTRY_W-1:0] rd_data;

   logic               req_fire;
   logic               slot_free;
   logic [PROD_W-1:0]  hash_prod;
   logic [IDX_W-1:0]   hash_idx;
   logic [IDX_W-1:0]   next_addr;
   logic [EPOCH_W-1:0] rd_epoch;
   logic [VALUE_W-1:0] rd_value;
   logic               slot_live;
   logic               slot_match;

   sdf_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (SEEN_CAPACITY)
   ) u_table (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // handshakes
   assign req_chan.ready        = (state_ff == ST_IDLE);
   assign req_fire              = req_chan.valid && req_chan.ready;
   assign rsp_chan.valid        = rsp_valid_ff;
   assign rsp_chan.kept_value   = rsp_value_ff;
   assign rsp_chan.set_overflow = rsp_ovf_ff;
   assign slot_free             = !rsp_valid_ff || rsp_chan.ready;

   // home slot: scale the folded key into the table range
   assign hash_prod = PROD_W'(fold_value(item_ff)) * PROD_W'(SEEN_CAPACITY);
   assign hash_idx  = hash_prod[HASH_W +: IDX_W];

   // linear probe step with wrap
   assign next_addr = (addr_ff == IDX_LAST) ? '0 : addr_ff + IDX_W'(1);

   // compare the slot just read
   assign rd_epoch   = rd_data[VALUE_W +: EPOCH_W];
   assign rd_value   = rd_data[VALUE_W-1:0];
   assign slot_live  = (rd_epoch == epoch_ff);
   assign slot_match = slot_live && (rd_value == item_ff);

   // controller
   always_comb begin
      state_in     = state_ff;
      epoch_in     = epoch_ff;
      count_in     = count_ff;
      probe_cnt_in = probe_cnt_ff;
      sweep_in     = sweep_ff;
      item_pend_in = item_pend_ff;
      item_in      = item_ff;
      addr_in      = addr_ff;
      ovf_in       = ovf_ff;
      wr_en        = 1'b0;
      wr_addr      = addr_ff;
      wr_data      = {epoch_ff, item_ff};
      rd_en        = 1'b0;
      rd_addr      = hash_idx;

      unique case (state_ff)
         ST_SWEEP: begin
            // clear one slot per cycle
            wr_en   = 1'b1;
            wr_addr = sweep_ff;
            wr_data = {EPOCH_NONE, VALUE_W'(0)};
            if (sweep_ff == IDX_LAST) begin
               sweep_in     = '0;
               epoch_in     = EPOCH_FIRST;
               item_pend_in = 1'b0;
               state_in     = item_pend_ff ? ST_HASH : ST_IDLE;
            end else begin
               sweep_in = sweep_ff + IDX_W'(1);
            end
         end
         ST_IDLE: begin
            if (req_fire) begin
               item_in = req_chan.item_value;
               if (req_chan.starts_new_list) begin
                  count_in = '0;
                  if (epoch_ff == EPOCH_LAST) begin
                     item_pend_in = 1'b1;
                     state_in     = ST_SWEEP;
                  end else begin
                     epoch_in = epoch_ff + EPOCH_W'(1);
                     state_in = ST_HASH;
                  end
               end else begin
                  state_in = ST_HASH;
               end
            end
         end
         ST_HASH: begin
            // read the home slot
            rd_en        = 1'b1;
            rd_addr      = hash_idx;
            addr_in      = hash_idx;
            probe_cnt_in = '0;
            state_in     = ST_LOOK;
         end
         ST_LOOK: begin
            priority if (slot_match) begin
               // repeat: drop
               state_in = ST_IDLE;
            end else if (!slot_live) begin
               // free slot: record the value
               wr_en    = 1'b1;
               wr_addr  = addr_ff;
               wr_data  = {epoch_ff, item_ff};
               count_in = count_ff + CNT_W'(1);
               ovf_in   = 1'b0;
               state_in = ST_EMIT;
            end else if (probe_cnt_ff == PROBE_LAST) begin
               // every slot holds another value
               ovf_in   = 1'b1;
               state_in = ST_EMIT;
            end else begin
               rd_en        = 1'b1;
               rd_addr      = next_addr;
               addr_in      = next_addr;
               probe_cnt_in = probe_cnt_ff + CNT_W'(1);
            end
         end
         ST_EMIT: begin
            if (slot_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // output register
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_value_in = rsp_value_ff;
      rsp_ovf_in   = rsp_ovf_ff;
      if (rsp_valid_ff && rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end
      if (state_ff == ST_EMIT && slot_free) begin
         rsp_valid_in = 1'b1;
         rsp_value_in = item_ff;
         rsp_ovf_in   = ovf_ff;
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_SWEEP;
         epoch_ff     <= EPOCH_NONE;
         count_ff     <= '0;
         probe_cnt_ff <= '0;
         sweep_ff     <= '0;
         item_pend_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         epoch_ff     <= epoch_in;
         count_ff     <= count_in;
         probe_cnt_ff <= probe_cnt_in;
         sweep_ff     <= sweep_in;
         item_pend_ff <= item_pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      item_ff      <= item_in;
      addr_ff      <= addr_in;
      ovf_ff       <= ovf_in;
      rsp_value_ff <= rsp_value_in;
      rsp_ovf_ff   <= rsp_ovf_in;
   end

   // checks
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_FULL)
      else $error("seen count beyond table size");

   a_insert_room: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_LOOK && wr_en) |-> (count_ff < CNT_FULL))
      else $error("insert into a full table");

   a_epoch_live: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_IDLE) |-> (epoch_ff != EPOCH_NONE))
      else $error("idle with the cleared-slot tag as live generation");

   a_overflow_full: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_LOOK && state_in == ST_EMIT && ovf_in) |-> (count_ff == CNT_FULL))
      else $error("overflow flagged while table has room");

   a_emit_loads: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_EMIT && slot_free) |=> (rsp_valid_ff && rsp_value_ff == $past(item_ff)))
      else $error("result not loaded into output register");

endmodule

`default_nettype wire

/* tb/stream_duplicate_filter_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stream_duplicate_filter_tb
// self-checking bench for the first-occurrence filter: a directed opener, then
// random lists, restart storms and one fill of the whole seen set, under three
// pacing phases and one long result stall; every result is checked in order
// against a behavioral model of the seen set
// ----------------------------------------------------------------------------

module stream_duplicate_filter_tb
   import sdf_pkg::*;
;

   localparam int CLK_PERIOD   = 10;
   localparam int SEEN_CAP     = 256;
   localparam int HOLD_CYCLES  = 400;
   localparam int STALL_LIMIT  = 4000;
   localparam int DRAIN_CYCLES = 2 * SEEN_CAP + 16;
   localparam int POOL_SIZE    = 16;

   localparam logic [VALUE_W-1:0] VALUE_MIN  = 32'h8000_0000;
   localparam logic [VALUE_W-1:0] VALUE_MAX  = 32'h7FFF_FFFF;
   localparam logic [VALUE_W-1:0] VALUE_ONES = 32'hFFFF_FFFF;

   // values built around each of these keys fold onto one table slot per key
   localparam logic [15:0] HOT_KEY_A = 16'h00A5;
   localparam logic [15:0] HOT_KEY_B = 16'h3C0F;

   typedef struct packed {
      logic [VALUE_W-1:0] item_value;
      logic               starts_new_list;
   } dedup_req_type;

   typedef struct packed {
      logic [VALUE_W-1:0] kept_value;
      logic               set_overflow;
   } dedup_rsp_type;

   typedef enum logic [1:0] {
      PACE_SLOW_SINK,
      PACE_SLOW_SOURCE,
      PACE_STEADY
   } pace_type;

   logic          clock     = 1'b0;
   logic          reset     = 1'b1;
   logic          req_valid = 1'b0;
   dedup_req_type req_item  = '0;
   logic          rsp_ready = 1'b0;

   pace_type pace       = PACE_SLOW_SINK;
   int    send_idle_pct = 17;
   int    recv_idle_pct = 51;

   dedup_req_type      item_backlog[$];
   dedup_rsp_type      kept_due[$];
   logic [VALUE_W-1:0] seen_set[$];
   logic [VALUE_W-1:0] value_pool[POOL_SIZE];

   int items_queued   = 0;
   int req_accepts    = 0;
   int accepts_seen   = 0;
   int mismatch_count = 0;
   int stall_cycles   = 0;
   int hold_left      = 0;
   bit hold_done      = 1'b0;

   sdf_req_if req_chan ();
   sdf_rsp_if rsp_chan ();

   assign req_chan.valid           = req_valid;
   assign req_chan.item_value      = req_item.item_value;
   assign req_chan.starts_new_list = req_item.starts_new_list;
   assign rsp_chan.ready           = rsp_ready;

   stream_duplicate_filter #(
      .SEEN_CAPACITY (SEEN_CAP)
   ) i_dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   always #(CLK_PERIOD / 2) clock = ~clock;

   // seen-set model: empty on a new list, drop repeats, flag values that do not fit
   function automatic void filter_first_seen(input dedup_req_type rq);
      dedup_rsp_type rs;
      bit            found;
      if (rq.starts_new_list) seen_set.delete();
      found = 1'b0;
      foreach (seen_set[i]) begin
         if (seen_set[i] == rq.item_value) found = 1'b1;
      end
      if (!found) begin
         rs.kept_value   = rq.item_value;
         rs.set_overflow = (seen_set.size() >= SEEN_CAP);
         if (!rs.set_overflow) seen_set = {seen_set, rq.item_value};
         kept_due = {kept_due, rs};
      end
   endfunction

   function automatic void push_item(input logic [VALUE_W-1:0] v, input logic start);
      dedup_req_type rq;
      rq.item_value      = v;
      rq.starts_new_list = start;
      item_backlog = {item_backlog, rq};
      items_queued++;
   endfunction

   // random value whose two halves xor to the key, so it lands on a crowded slot
   function automatic logic [VALUE_W-1:0] fold_twin(input logic [15:0] key);
      logic [15:0] hi;
      hi = 16'($urandom);
      return {hi, hi ^ key};
   endfunction

   // lists with random content: mostly short, some long, some without a restart,
   // with a share of noise items carrying a random restart bit
   task automatic push_random_lists(input int n_items);
      int                 stop_at;
      int                 kind;
      int                 len;
      int                 sel;
      logic [VALUE_W-1:0] v;
      logic [VALUE_W-1:0] recent[$];
      stop_at = items_queued + n_items;
      while (items_queued < stop_at) begin
         kind = $urandom_range(99);
         recent.delete();
         if (kind < 10) begin
            repeat (4) push_item($urandom, 1'($urandom_range(1)));
         end else begin
            if (kind < 75) len = $urandom_range(1, 3);
            else if (kind < 90) len = $urandom_range(8, 24);
            else len = $urandom_range(1, 4);
            for (int k = 0; k < len; k++) begin
               sel = $urandom_range(99);
               if (sel < 35 && recent.size() != 0) v = recent[$urandom_range(recent.size() - 1)];
               else if (sel < 60) v = value_pool[$urandom_range(POOL_SIZE - 1)];
               else if (sel < 80) v = fold_twin(sel[0] ? HOT_KEY_A : HOT_KEY_B);
               else v = $urandom;
               recent = {recent, v};
               push_item(v, k == 0 && kind < 90);
            end
         end
      end
   endtask

   // request driver: hold an offer until taken, otherwise offer or idle
   always @(negedge clock) begin : req_driver
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_accepts != accepts_seen) begin
         accepts_seen = req_accepts;
         if (item_backlog.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
            req_item  <= item_backlog.pop_front();
            req_valid <= 1'b1;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // result receiver: random stalls, one long hold-off at the start of the steady phase
   always @(negedge clock) begin : rsp_receiver
      if (reset) begin
         rsp_ready <= 1'b0;
      end else if (hold_left != 0) begin
         hold_left--;
         rsp_ready <= 1'b0;
      end else if (pace == PACE_STEADY && !hold_done) begin
         hold_done = 1'b1;
         hold_left = HOLD_CYCLES - 1;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   // accepted requests go through the model
   always @(posedge clock) begin : req_monitor
      if (!reset && req_valid && req_chan.ready) begin
         req_accepts <= req_accepts + 1;
         filter_first_seen(req_item);
      end
   end

   // accepted results are checked against the oldest expectation
   always @(posedge clock) begin : rsp_monitor
      dedup_rsp_type due;
      if (!reset && rsp_chan.valid && rsp_ready) begin
         if (kept_due.size() == 0) begin
            $display("%0t: unexpected result, kept_value %h set_overflow %0b", $time,
                     rsp_chan.kept_value, rsp_chan.set_overflow);
            mismatch_count++;
         end else begin
            due = kept_due.pop_front();
            if (rsp_chan.kept_value !== due.kept_value) begin
               $display("%0t: kept_value expected %h, actual %h", $time,
                        due.kept_value, rsp_chan.kept_value);
               mismatch_count++;
            end
            if (rsp_chan.set_overflow !== due.set_overflow) begin
               $display("%0t: set_overflow for %h expected %0b, actual %0b", $time,
                        due.kept_value, due.set_overflow, rsp_chan.set_overflow);
               mismatch_count++;
            end
         end
      end
   end

   // watchdog on cycles without any handshake
   always @(posedge clock) begin : watchdog
      if (reset || (req_valid && req_chan.ready) || (rsp_chan.valid && rsp_ready)) begin
         stall_cycles <= 0;
      end else if (stall_cycles >= STALL_LIMIT) begin
         $display("%0t: no handshake for %0d cycles, %0d results outstanding", $time,
                  stall_cycles, kept_due.size());
         $display("TEST FAILED");
         $finish;
      end else begin
         stall_cycles <= stall_cycles + 1;
      end
   end

   initial begin : stimulus
      logic [VALUE_W-1:0] v;
      logic [VALUE_W-1:0] twin;
      bit                 fill_used[logic [VALUE_W-1:0]];
      logic [VALUE_W-1:0] fill_order[$];

      // pool of extremes and crowded-slot values shared by the random lists
      value_pool[0] = '0;
      value_pool[1] = VALUE_ONES;
      value_pool[2] = VALUE_MIN;
      value_pool[3] = VALUE_MAX;
      value_pool[4] = 32'h0000_0001;
      value_pool[5] = 32'hAAAA_AAAA;
      value_pool[6] = 32'h5555_5555;
      for (int i = 7; i < POOL_SIZE; i++) value_pool[i] = fold_twin(i[0] ? HOT_KEY_A : HOT_KEY_B);

      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed opener: extremes, repeats, restart on a repeat, slot collisions
      push_item('0, 1'b0);
      push_item('0, 1'b0);
      push_item(VALUE_MAX, 1'b0);
      push_item(VALUE_MIN, 1'b0);
      push_item(VALUE_ONES, 1'b0);
      push_item(32'h0000_0001, 1'b0);
      push_item(VALUE_MIN, 1'b0);
      push_item(VALUE_ONES, 1'b1);
      push_item('0, 1'b0);
      push_item(VALUE_ONES, 1'b0);
      v = fold_twin(HOT_KEY_A);
      do twin = fold_twin(HOT_KEY_A); while (twin == v);
      push_item(v, 1'b0);
      push_item(twin, 1'b0);
      push_item(v, 1'b0);
      push_item(twin, 1'b0);
      push_item(twin, 1'b1);
      push_item(v, 1'b0);
      push_item(32'hAAAA_AAAA, 1'b0);
      push_item(32'h5555_5555, 1'b0);
      push_item(VALUE_MAX, 1'b0);
      push_item(VALUE_MAX, 1'b0);

      for (int p = 0; p < 3; p++) begin
         pace = pace_type'(p);
         case (pace)
            PACE_SLOW_SINK: begin
               send_idle_pct = 17;
               recv_idle_pct = 51;
            end
            PACE_SLOW_SOURCE: begin
               send_idle_pct = 51;
               recv_idle_pct = 17;
            end
            default: begin
               send_idle_pct = 0;
               recv_idle_pct = 0;
            end
         endcase

         push_random_lists(110);

         // restart storm: every request opens a new list, often on the same value
         repeat (60) begin
            if ($urandom_range(1) == 1) v = value_pool[$urandom_range(POOL_SIZE - 1)];
            push_item(v, 1'b1);
         end

         // one list that fills the whole seen set, then repeats and overflows
         if (pace == PACE_STEADY) begin
            fill_used.delete();
            fill_order.delete();
            v = fold_twin(HOT_KEY_A);
            fill_used[v] = 1'b1;
            fill_order = {fill_order, v};
            push_item(v, 1'b1);
            while (fill_order.size() < SEEN_CAP) begin
               v = ($urandom_range(1) == 1) ? fold_twin(HOT_KEY_A) : $urandom;
               if (!fill_used.exists(v)) begin
                  fill_used[v] = 1'b1;
                  fill_order = {fill_order, v};
                  push_item(v, 1'b0);
               end
            end
            push_item(fill_order[0], 1'b0);
            push_item(fill_order[SEEN_CAP - 1], 1'b0);
            do v = fold_twin(HOT_KEY_A); while (fill_used.exists(v));
            push_item(v, 1'b0);
            push_item(v, 1'b0);
            repeat (8) push_item(fill_order[$urandom_range(SEEN_CAP - 1)], 1'b0);
            repeat (6) begin
               do v = ($urandom_range(1) == 1) ? fold_twin(HOT_KEY_B) : $urandom;
               while (fill_used.exists(v));
               push_item(v, 1'b0);
            end
            push_item(fill_order[5], 1'b1);
            push_item(fill_order[5], 1'b0);
         end

         while (req_accepts != items_queued) @(posedge clock);
      end

      // wait for the last results, then let any stray one show up
      while (req_accepts != items_queued || kept_due.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule

/* filelist.f */
sv/sdf_pkg.sv
sv/sdf_req_if.sv
sv/sdf_rsp_if.sv
sv/sdf_ram.sv
sv/stream_duplicate_filter.sv
tb/stream_duplicate_filter_tb.sv
